FILE: rtl/core/tlpjd_pkg.sv
package tlpjd_pkg;

    // Default sizes
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TICKET_BITS = 16;

    // Fixed field widths
    localparam int OUT_TICKET_W = 16;
    localparam int LIMIT_W      = 4;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd2;

    // Register index, taken from paddr[2]
    localparam logic REG_REMOTE_LIMIT = 1'b0;
    localparam logic REG_LOCAL_LIMIT  = 1'b1;

    typedef enum logic [2:0] {
        OP_ENQUEUE    = 3'd0,
        OP_DISPATCH   = 3'd1,
        OP_COMPLETE   = 3'd2,
        OP_CANCEL     = 3'd3,
        OP_CANCEL_ALL = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NONE   = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic    latch;
        logic    rd_en;
        logic    wr_up;
        logic    wr_down;
        logic    wr_new;
        logic    capture;
        logic    finish;
        t_status status;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic urgent;
        logic full;
        logic empty;
        logic rd_vld;
        logic hit;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/core/tlpjd_in_if.sv
interface tlpjd_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic        over_link;
    logic        urgent;
    logic [15:0] target_ticket;

    modport source (output valid, output operation, output over_link, output urgent,
                    output target_ticket, input ready);
    modport sink   (input valid, input operation, input over_link, input urgent,
                    input target_ticket, output ready);
endinterface

FILE: rtl/core/tlpjd_out_if.sv
interface tlpjd_out_if #(
    parameter int WAIT_W = 5
);
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [15:0]       ticket;
    logic              lane;
    logic              idle;
    logic [WAIT_W-1:0] waiting;

    modport source (output valid, output status, output ticket, output lane, output idle,
                    output waiting, input ready);
    modport sink   (input valid, input status, input ticket, input lane, input idle,
                    input waiting, output ready);
endinterface

FILE: rtl/core/tlpjd_datapath.sv
module tlpjd_datapath #(
    parameter int QUEUE_DEPTH = tlpjd_pkg::DEF_QUEUE_DEPTH,
    parameter int TICKET_BITS = tlpjd_pkg::DEF_TICKET_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  tlpjd_pkg::t_dp_cmd                     i_cmd,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]         i_addr,
    output tlpjd_pkg::t_dp_sts                     o_sts,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]       o_wcount,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]       o_ucount,
    // job fields
    input  logic [2:0]                             i_operation,
    input  logic                                   i_over_link,
    input  logic                                   i_urgent,
    input  logic [15:0]                            i_target_ticket,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [tlpjd_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [tlpjd_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [tlpjd_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                   pready,
    // results
    tlpjd_out_if.source                            o_res
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH+1);
    localparam int EW = TICKET_BITS + 2;
    localparam int TW = tlpjd_pkg::OUT_TICKET_W;
    localparam int LW = tlpjd_pkg::LIMIT_W;

    // Queue storage: {ticket, remote, urgent}
    logic [EW-1:0] r_mem [QUEUE_DEPTH];
    logic [EW-1:0] r_rd_data;
    logic [AW-1:0] r_rd_addr_q;
    logic          r_rd_vld_q;

    logic [CW-1:0]          r_wcount, n_wcount;
    logic [CW-1:0]          r_ucount, n_ucount;
    logic [LW-1:0]          r_busy_remote, n_busy_remote;
    logic [LW-1:0]          r_busy_local, n_busy_local;
    logic [TICKET_BITS-1:0] r_next_ticket, n_next_ticket;
    logic [TICKET_BITS-1:0] tick_inc;
    logic [LW-1:0]          r_remote_limit;
    logic [LW-1:0]          r_local_limit;

    // Latched job
    tlpjd_pkg::t_op r_op;
    logic           r_over_link;
    logic           r_urgent;
    logic [15:0]    r_target;

    // Entry found by the scan
    logic [TICKET_BITS-1:0] r_hit_ticket;
    logic                   r_hit_remote;
    logic                   r_hit_urgent;

    // Result register
    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [TW-1:0]     r_out_ticket;
    logic              r_out_lane;
    logic              r_out_idle;
    logic [CW-1:0]     r_out_waiting;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [EW-1:0]          wr_data;
    logic [TICKET_BITS-1:0] rd_ticket;
    logic                   rd_remote;
    logic [TICKET_BITS+TW-1:0] rd_ticket_ext;
    logic [TICKET_BITS+TW-1:0] hit_ticket_ext;
    logic [TICKET_BITS+TW-1:0] new_ticket_ext;
    logic                   room;
    logic                   match;
    logic [TW-1:0]          n_out_ticket;
    logic                   n_out_lane;
    logic                   cfg_wr;

    // Unpack the entry read last cycle
    assign rd_ticket      = r_rd_data[EW-1:2];
    assign rd_remote      = r_rd_data[1];
    assign rd_ticket_ext  = {{TW{1'b0}}, rd_ticket};
    assign hit_ticket_ext = {{TW{1'b0}}, r_hit_ticket};
    assign new_ticket_ext = {{TW{1'b0}}, r_next_ticket};

    // Lane room and ticket compare for the scan
    assign room  = rd_remote ? (r_busy_remote < r_remote_limit)
                             : (r_busy_local < r_local_limit);
    assign match = (rd_ticket_ext[TW-1:0] == r_target);

    // Write port: shift moves reuse the registered read data
    assign wr_en   = i_cmd.wr_new | ((i_cmd.wr_up | i_cmd.wr_down) & r_rd_vld_q);
    assign wr_addr = i_cmd.wr_new ? i_addr
                   : (i_cmd.wr_up ? r_rd_addr_q + 1'b1 : r_rd_addr_q - 1'b1);
    assign wr_data = i_cmd.wr_new ? {r_next_ticket, r_over_link, r_urgent} : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data   <= r_mem[i_addr];
            r_rd_addr_q <= i_addr;
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.op       = r_op;
        o_sts.urgent   = r_urgent;
        o_sts.full     = (r_wcount == CW'(QUEUE_DEPTH));
        o_sts.empty    = (r_wcount == '0);
        o_sts.rd_vld   = r_rd_vld_q;
        o_sts.hit      = r_rd_vld_q & (((r_op == tlpjd_pkg::OP_DISPATCH) & room) |
                                       ((r_op == tlpjd_pkg::OP_CANCEL) & match));
        o_sts.out_free = ~r_out_valid | o_res.ready;
    end
    assign o_wcount = r_wcount;
    assign o_ucount = r_ucount;

    // Next ticket wraps past zero to one
    assign tick_inc = r_next_ticket + 1'b1;

    // Counter updates when the operation finishes
    always_comb begin
        n_wcount      = r_wcount;
        n_ucount      = r_ucount;
        n_busy_remote = r_busy_remote;
        n_busy_local  = r_busy_local;
        n_next_ticket = r_next_ticket;
        n_out_ticket  = '0;
        n_out_lane    = 1'b0;
        unique case (r_op)
            tlpjd_pkg::OP_ENQUEUE: begin
                if (i_cmd.status == tlpjd_pkg::ST_OK) begin
                    n_wcount      = r_wcount + 1'b1;
                    n_ucount      = r_ucount + CW'(r_urgent);
                    n_next_ticket = (tick_inc == '0) ? TICKET_BITS'(1) : tick_inc;
                    n_out_ticket  = new_ticket_ext[TW-1:0];
                end
            end
            tlpjd_pkg::OP_DISPATCH: begin
                if (i_cmd.status == tlpjd_pkg::ST_OK) begin
                    n_wcount     = r_wcount - 1'b1;
                    n_ucount     = r_ucount - CW'(r_hit_urgent);
                    n_out_ticket = hit_ticket_ext[TW-1:0];
                    n_out_lane   = r_hit_remote;
                    if (r_hit_remote) begin
                        n_busy_remote = r_busy_remote + 1'b1;
                    end else begin
                        n_busy_local = r_busy_local + 1'b1;
                    end
                end
            end
            tlpjd_pkg::OP_COMPLETE: begin
                if (r_over_link) begin
                    if (r_busy_remote != '0) n_busy_remote = r_busy_remote - 1'b1;
                end else begin
                    if (r_busy_local != '0) n_busy_local = r_busy_local - 1'b1;
                end
            end
            tlpjd_pkg::OP_CANCEL: begin
                if (i_cmd.status == tlpjd_pkg::ST_OK) begin
                    n_wcount = r_wcount - 1'b1;
                    n_ucount = r_ucount - CW'(r_hit_urgent);
                end
            end
            tlpjd_pkg::OP_CANCEL_ALL: begin
                n_wcount = '0;
                n_ucount = '0;
            end
            default: begin
                // unused codes change nothing
            end
        endcase
    end

    // Latch the job, the scan hit and the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op        <= tlpjd_pkg::t_op'(i_operation);
            r_over_link <= i_over_link;
            r_urgent    <= i_urgent;
            r_target    <= i_target_ticket;
        end
        if (i_cmd.capture) begin
            r_hit_ticket <= rd_ticket;
            r_hit_remote <= rd_remote;
            r_hit_urgent <= r_rd_data[0];
        end
        if (i_cmd.finish) begin
            r_out_status  <= i_cmd.status;
            r_out_ticket  <= n_out_ticket;
            r_out_lane    <= n_out_lane;
            r_out_idle    <= (n_wcount == '0) && (n_busy_remote == '0) &&
                             (n_busy_local == '0);
            r_out_waiting <= n_wcount;
        end
    end

    assign cfg_wr = psel & penable & pwrite;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld_q     <= 1'b0;
            r_wcount       <= '0;
            r_ucount       <= '0;
            r_busy_remote  <= '0;
            r_busy_local   <= '0;
            r_next_ticket  <= TICKET_BITS'(1);
            r_remote_limit <= tlpjd_pkg::LIMIT_RESET;
            r_local_limit  <= tlpjd_pkg::LIMIT_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            r_rd_vld_q <= i_cmd.rd_en;
            if (i_cmd.finish) begin
                r_wcount      <= n_wcount;
                r_ucount      <= n_ucount;
                r_busy_remote <= n_busy_remote;
                r_busy_local  <= n_busy_local;
                r_next_ticket <= n_next_ticket;
            end
            // write a limit
            if (cfg_wr) begin
                if (paddr[2] == tlpjd_pkg::REG_LOCAL_LIMIT) begin
                    r_local_limit <= pwdata[LW-1:0];
                end else begin
                    r_remote_limit <= pwdata[LW-1:0];
                end
            end
            // hold the result until its transfer
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Register read back
    assign prdata = (paddr[2] == tlpjd_pkg::REG_LOCAL_LIMIT)
                  ? {{(tlpjd_pkg::CFG_DATA_W-LW){1'b0}}, r_local_limit}
                  : {{(tlpjd_pkg::CFG_DATA_W-LW){1'b0}}, r_remote_limit};
    assign pready = 1'b1;

    assign o_res.valid   = r_out_valid;
    assign o_res.status  = r_out_status;
    assign o_res.ticket  = r_out_ticket;
    assign o_res.lane    = r_out_lane;
    assign o_res.idle    = r_out_idle;
    assign o_res.waiting = r_out_waiting;

endmodule

FILE: rtl/core/tlpjd_ctrl.sv
module tlpjd_ctrl #(
    parameter int QUEUE_DEPTH = tlpjd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  tlpjd_pkg::t_dp_sts               i_sts,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] i_wcount,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] i_ucount,
    output tlpjd_pkg::t_dp_cmd               o_cmd,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   o_addr
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH+1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ENQ_SHIFT,
        S_ENQ_WRITE,
        S_SCAN,
        S_REMOVE,
        S_FINISH
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_pos, n_pos;
    logic                r_drain, n_drain;
    tlpjd_pkg::t_status  r_status, n_status;
    logic [CW-1:0]       enq_pos;

    assign enq_pos = i_sts.urgent ? i_ucount : i_wcount;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_drain  = r_drain;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;
        o_in_ready   = 1'b0;
        o_addr = (r_state == S_ENQ_WRITE) ? r_pos[AW-1:0] : r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_status = tlpjd_pkg::ST_OK;
                n_state  = S_FINISH;
                unique case (i_sts.op)
                    tlpjd_pkg::OP_ENQUEUE: begin
                        if (i_sts.full) begin
                            n_status = tlpjd_pkg::ST_FULL;
                        end else begin
                            n_pos   = enq_pos;
                            n_idx   = i_wcount - 1'b1;
                            n_drain = 1'b0;
                            n_state = (enq_pos == i_wcount) ? S_ENQ_WRITE : S_ENQ_SHIFT;
                        end
                    end
                    tlpjd_pkg::OP_DISPATCH, tlpjd_pkg::OP_CANCEL: begin
                        if (i_sts.empty) begin
                            n_status = (i_sts.op == tlpjd_pkg::OP_DISPATCH)
                                     ? tlpjd_pkg::ST_NONE : tlpjd_pkg::ST_ABSENT;
                        end else begin
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        // complete, cancel all and unused codes finish at once
                    end
                endcase
            end
            S_ENQ_SHIFT: begin
                // read from the tail down, write each entry one place back
                o_cmd.wr_up = 1'b1;
                if (!r_drain) begin
                    o_cmd.rd_en = 1'b1;
                    if (r_idx == r_pos) begin
                        n_drain = 1'b1;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end else begin
                    n_drain = 1'b0;
                    n_state = S_ENQ_WRITE;
                end
            end
            S_ENQ_WRITE: begin
                o_cmd.wr_new = 1'b1;
                n_status     = tlpjd_pkg::ST_OK;
                n_state      = S_FINISH;
            end
            S_SCAN: begin
                // one entry read per cycle, each checked in the following cycle
                if (r_idx < i_wcount) begin
                    o_cmd.rd_en = 1'b1;
                    n_idx       = r_idx + 1'b1;
                end
                if (i_sts.hit) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_REMOVE;
                end else if (i_sts.rd_vld && (r_idx == i_wcount)) begin
                    n_status = (i_sts.op == tlpjd_pkg::OP_DISPATCH)
                             ? tlpjd_pkg::ST_NONE : tlpjd_pkg::ST_ABSENT;
                    n_state  = S_FINISH;
                end
            end
            S_REMOVE: begin
                // close the gap: each later entry moves one place forward
                o_cmd.wr_down = 1'b1;
                if (r_idx < i_wcount) begin
                    o_cmd.rd_en = 1'b1;
                    n_idx       = r_idx + 1'b1;
                end
                if (!i_sts.rd_vld) begin
                    n_status = tlpjd_pkg::ST_OK;
                    n_state  = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_pos    <= '0;
            r_drain  <= 1'b0;
            r_status <= tlpjd_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_pos    <= n_pos;
            r_drain  <= n_drain;
            r_status <= n_status;
        end
    end

endmodule

FILE: rtl/core/two_lane_priority_job_dispatcher.sv
// Steps from the input transfer to result valid: complete, cancel all, unused codes,
// enqueue on a full queue and dispatch or cancel on an empty queue go straight to finish;
// enqueue moves any entries behind its place back, then writes the new entry; dispatch
// and cancel scan the queue and, on a hit, close the gap before the result loads.
// One job at a time: input is ready again only after the result loads. Reset (synchronous,
// active low) empties the queue, clears busy counts, sets next ticket to 1 and both lane
// limits to 2; queue memory is not cleared.
module two_lane_priority_job_dispatcher #(
    parameter int QUEUE_DEPTH = tlpjd_pkg::DEF_QUEUE_DEPTH,
    parameter int TICKET_BITS = tlpjd_pkg::DEF_TICKET_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tlpjd_in_if.sink                         i_job,
    tlpjd_out_if.source                      o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tlpjd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tlpjd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tlpjd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH+1);

    tlpjd_pkg::t_dp_cmd cmd;
    tlpjd_pkg::t_dp_sts sts;
    logic [AW-1:0]      addr;
    logic [CW-1:0]      wcount;
    logic [CW-1:0]      ucount;
    logic               in_ready;

    assign i_job.ready = in_ready;

    tlpjd_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_job.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .i_wcount   (wcount),
        .i_ucount   (ucount),
        .o_cmd      (cmd),
        .o_addr     (addr)
    );

    tlpjd_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TICKET_BITS (TICKET_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_addr          (addr),
        .o_sts           (sts),
        .o_wcount        (wcount),
        .o_ucount        (ucount),
        .i_operation     (i_job.operation),
        .i_over_link     (i_job.over_link),
        .i_urgent        (i_job.urgent),
        .i_target_ticket (i_job.target_ticket),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_res           (o_res)
    );

endmodule

FILE: rtl/core/tlpjd_checker.sv
module tlpjd_checker #(
    parameter int QUEUE_DEPTH = tlpjd_pkg::DEF_QUEUE_DEPTH
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [1:0]                       i_status,
    input logic [15:0]                      i_ticket,
    input logic                             i_lane,
    input logic                             i_idle,
    input logic [$clog2(QUEUE_DEPTH+1)-1:0] i_waiting
);

    localparam int CW = $clog2(QUEUE_DEPTH+1);

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // One job at a time: input closes after a transfer
    a_one_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a transfer");

    // Failures carry no ticket and no lane
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != tlpjd_pkg::ST_OK)) |-> ((i_ticket == '0) && !i_lane))
        else $error("failed operation reports a ticket or lane");

    // Idle means an empty queue, and the count stays within depth
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((!i_idle || (i_waiting == '0)) && (i_waiting <= CW'(QUEUE_DEPTH))))
        else $error("waiting count inconsistent");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_ticket)
                                           && $stable(i_status)))
        else $error("stalled result changed");

endmodule

bind two_lane_priority_job_dispatcher tlpjd_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_job.valid),
    .i_in_ready  (i_job.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_ticket    (o_res.ticket),
    .i_lane      (o_res.lane),
    .i_idle      (o_res.idle),
    .i_waiting   (o_res.waiting)
);
